@@ hw/rtl/ohlcv_bar_time_bucket_core_defines.svh @@
// Assertion macros shared by the bar builder modules.
`ifndef OHLCV_BAR_TIME_BUCKET_CORE_DEFINES_SVH
`define OHLCV_BAR_TIME_BUCKET_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define OBTB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("obtb assertion failed");
`define OBTB_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("obtb assertion failed");
`else
`define OBTB_ASSERT(lbl, prop)
`define OBTB_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ hw/rtl/obtb_pkg.sv @@
// Types and constants of the OHLCV time bucket bar builder.
`timescale 1ns / 1ps
package obtb_pkg;

	localparam logic [31:0] PERIOD_RESET = 32'd60;
	localparam logic [31:0] PERIOD_MIN   = 32'd1;

	// queue between bucket divider and bar update
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [31:0] tick_time;
		logic [31:0] tick_price;
		logic [30:0] tick_volume;
	} tick_t;

	typedef struct packed {
		logic [31:0] bar_start;
		logic [31:0] bar_open;
		logic [31:0] bar_high;
		logic [31:0] bar_low;
		logic [31:0] bar_close;
		logic [47:0] bar_volume;
		logic        new_bar;
		logic [15:0] empty_skipped;
	} bar_t;

	// tick after bucket classification
	typedef struct packed {
		logic [31:0] idx;
		logic [31:0] start;
		logic [31:0] price;
		logic [30:0] volume;
	} cls_t;

endpackage

@@ hw/rtl/obtb_div.sv @@
// Front end: accepts ticks and finds bucket index and bucket start by serial division.
`timescale 1ns / 1ps
module obtb_div import obtb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] period,
	input  logic        tick_valid,
	output logic        tick_stall,
	input  tick_t       tick,
	output logic        push,
	output cls_t        push_data,
	input  logic        full
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]  state_q;
	logic [4:0]  cnt_q;
	logic [31:0] div_q;
	logic [31:0] rem_q;
	logic [31:0] dq_q;
	logic [31:0] time_q;
	logic [31:0] price_q;
	logic [30:0] vol_q;
	logic [32:0] part;
	logic [32:0] trial;
	logic        ge;

	assign tick_stall = (state_q != ST_IDLE);

	// one quotient bit per cycle, restoring
	assign part  = {rem_q, dq_q[31]};
	assign trial = part - {1'b0, div_q};
	assign ge    = !trial[32];

	assign push = (state_q == ST_PUSH) && !full;
	always_comb begin
		push_data.idx    = dq_q;
		push_data.start  = time_q - rem_q;
		push_data.price  = price_q;
		push_data.volume = vol_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tick_valid) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && tick_valid) begin
			div_q   <= (period == '0) ? PERIOD_MIN : period;
			rem_q   <= '0;
			dq_q    <= tick.tick_time;
			time_q  <= tick.tick_time;
			price_q <= tick.tick_price;
			vol_q   <= tick.tick_volume;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? trial[31:0] : part[31:0];
			dq_q  <= {dq_q[30:0], ge};
		end
	end

endmodule

@@ hw/rtl/obtb_fifo.sv @@
// Short queue of classified ticks between divider and bar update.
`timescale 1ns / 1ps
`include "ohlcv_bar_time_bucket_core_defines.svh"
module obtb_fifo import obtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output cls_t pop_data,
	output logic not_empty
);

	cls_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`OBTB_ASSERT(a_no_push_full, !(push && full))
	`OBTB_ASSERT(a_no_pop_empty, !(pop && !not_empty))
	`OBTB_ASSERT_NEXT(a_cnt_grows, push && !pop, cnt_q == $past(cnt_q) + QCNT_W'(1))

endmodule

@@ hw/rtl/obtb_bar.sv @@
// Back end: updates the running bar and holds the result register.
`timescale 1ns / 1ps
`include "ohlcv_bar_time_bucket_core_defines.svh"
module obtb_bar import obtb_pkg::*; #(
	parameter int PRICE_BITS      = 32,
	parameter int VOLUME_ACC_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cls_t q_data,
	output logic pop,
	output logic bar_valid,
	input  logic bar_stall,
	output bar_t bar
);

	localparam int PW = (PRICE_BITS < 32) ? PRICE_BITS : 32;
	localparam int VA = VOLUME_ACC_BITS;

	logic [31:0]   cur_index_q;
	logic [31:0]   cur_start_q;
	logic [PW-1:0] open_q;
	logic [PW-1:0] high_q;
	logic [PW-1:0] low_q;
	logic [PW-1:0] close_q;
	logic [VA-1:0] vol_q;
	logic          has_bar_q;
	logic          bar_valid_q;
	bar_t          bar_q;

	logic          opens;
	logic [31:0]   gap;
	logic [15:0]   skip;
	logic [PW-1:0] p;
	logic [31:0]   n_start;
	logic [PW-1:0] n_open;
	logic [PW-1:0] n_high;
	logic [PW-1:0] n_low;
	logic [VA:0]   vsum;
	logic [VA-1:0] n_vol;
	logic [PW+31:0] open_x;
	logic [PW+31:0] high_x;
	logic [PW+31:0] low_x;
	logic [PW+31:0] close_x;
	logic [VA+47:0] vol_x;

	assign pop = q_valid && (!bar_valid_q || !bar_stall);

	always_comb begin
		opens   = !has_bar_q || (q_data.idx > cur_index_q);
		gap     = q_data.idx - cur_index_q - 32'd1;
		if (!has_bar_q) begin
			skip = '0;
		end else if (gap[31:16] != '0) begin
			skip = '1;
		end else begin
			skip = gap[15:0];
		end
		p       = q_data.price[PW-1:0];
		vsum    = {1'b0, vol_q} + (VA+1)'(q_data.volume);
		n_start = opens ? q_data.start : cur_start_q;
		n_open  = opens ? p : open_q;
		n_high  = (opens || p > high_q) ? p : high_q;
		n_low   = (opens || p < low_q) ? p : low_q;
		if (opens) begin
			n_vol = VA'(q_data.volume);
		end else if (vsum[VA]) begin
			n_vol = '1;
		end else begin
			n_vol = vsum[VA-1:0];
		end
		open_x  = {32'd0, n_open};
		high_x  = {32'd0, n_high};
		low_x   = {32'd0, n_low};
		close_x = {32'd0, p};
		vol_x   = {48'd0, n_vol};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_bar_q   <= 1'b0;
			bar_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				has_bar_q   <= 1'b1;
				bar_valid_q <= 1'b1;
			end else if (!bar_stall) begin
				bar_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (opens) begin
				cur_index_q <= q_data.idx;
			end
			cur_start_q <= n_start;
			open_q      <= n_open;
			high_q      <= n_high;
			low_q       <= n_low;
			close_q     <= p;
			vol_q       <= n_vol;
			bar_q.bar_start     <= n_start;
			bar_q.bar_open      <= open_x[31:0];
			bar_q.bar_high      <= high_x[31:0];
			bar_q.bar_low       <= low_x[31:0];
			bar_q.bar_close     <= close_x[31:0];
			bar_q.bar_volume    <= vol_x[47:0];
			bar_q.new_bar       <= opens;
			bar_q.empty_skipped <= opens ? skip : 16'd0;
		end
	end

	assign bar_valid = bar_valid_q;
	assign bar       = bar_q;

	`OBTB_ASSERT(a_no_pop_held, !(pop && bar_valid_q && bar_stall))
	`OBTB_ASSERT_NEXT(a_pop_loads, pop, bar_valid_q && has_bar_q)
	`OBTB_ASSERT(a_skip_new, !(bar_valid_q && bar_q.empty_skipped != '0 && !bar_q.new_bar))

endmodule

@@ hw/rtl/ohlcv_bar_time_bucket_core.sv @@
// Top level of the OHLCV time bucket bar builder.
//
// Ticks (time, price, volume) enter on the tick channel; a transaction takes
// place when tick_valid is high and tick_stall is low. Each tick yields one
// bar transaction on the bar channel (bar_valid / bar_stall): the bar that
// holds the tick after the tick is added, its start time, a new-bar flag and
// a saturating count of empty buckets skipped.
// The front divides the tick time by bucket_period one quotient bit per
// cycle; a tick occupies the front through accept, 32 divide steps and the
// queue write, and no new tick is taken before that write. A two-entry queue
// decouples the divider from the bar update, which finishes one queued tick
// per cycle into the result register unless a held bar is stalled there.
// A stalled bar stays in the result register; the queue fills, then the
// divider holds its result and tick_stall stays high until space frees.
// bucket_period is written through cfg_valid / cfg_ready (always ready);
// the user must write it only while idle, which the block does not enforce.
// A period of zero acts as one. Reset restores a period of 60, drops the
// current bar and empties the queue and result register.
`timescale 1ns / 1ps
module ohlcv_bar_time_bucket_core import obtb_pkg::*; #(
	parameter int PRICE_BITS      = 32,
	parameter int VOLUME_ACC_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        tick_valid,
	output logic        tick_stall,
	input  tick_t       tick,
	output logic        bar_valid,
	input  logic        bar_stall,
	output bar_t        bar
);

	logic [31:0] bucket_period_q;
	logic        push;
	cls_t        push_data;
	logic        full;
	logic        pop;
	cls_t        pop_data;
	logic        not_empty;

	// config register, no back pressure
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bucket_period_q <= cfg_data;
		end
	end

	// front: bucket index and start per tick
	obtb_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.period     (bucket_period_q),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	obtb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	// back: running OHLCV state and result register
	obtb_bar #(
		.PRICE_BITS      (PRICE_BITS),
		.VOLUME_ACC_BITS (VOLUME_ACC_BITS)
	) u_bar (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.bar_valid (bar_valid),
		.bar_stall (bar_stall),
		.bar       (bar)
	);

endmodule

@@ tb/sv/ohlcv_bar_time_bucket_checker.sv @@
// Scoreboard for the OHLCV time bucket bar builder: predicts every bar and compares it.
`timescale 1ns / 1ps
module ohlcv_bar_time_bucket_checker import obtb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        tick_valid,
	input  logic        tick_stall,
	input  tick_t       tick,
	input  logic        bar_valid,
	input  logic        bar_stall,
	input  bar_t        bar,
	output int          mismatches,
	output int          outstanding
);

	logic [31:0] period;
	logic [31:0] cur_bucket;
	logic        bar_live;
	bar_t        cur_bar;      // running bar; flag fields hold the latest tick's view
	bar_t        bars_due[$];
	bar_t        want;

	// Fold one accepted tick into the running bar and queue the bar it yields.
	task automatic fold_tick(input tick_t tk);
		logic [31:0] div;
		logic [31:0] bucket;
		logic [31:0] gap;
		logic [48:0] vsum;
		div = (period == '0) ? 32'd1 : period;
		bucket = tk.tick_time / div;
		if (!bar_live || bucket > cur_bucket) begin
			gap = bucket - cur_bucket - 32'd1;
			if (!bar_live)
				cur_bar.empty_skipped = '0;
			else
				cur_bar.empty_skipped = (gap > 32'd65535) ? 16'hFFFF : gap[15:0];
			cur_bar.new_bar    = 1'b1;
			cur_bar.bar_start  = tk.tick_time - (tk.tick_time % div);
			cur_bar.bar_open   = tk.tick_price;
			cur_bar.bar_high   = tk.tick_price;
			cur_bar.bar_low    = tk.tick_price;
			cur_bar.bar_close  = tk.tick_price;
			cur_bar.bar_volume = {17'd0, tk.tick_volume};
			cur_bucket = bucket;
			bar_live   = 1'b1;
		end else begin
			// same or older bucket: merge, start time stays
			cur_bar.new_bar       = 1'b0;
			cur_bar.empty_skipped = '0;
			cur_bar.bar_close     = tk.tick_price;
			if (tk.tick_price > cur_bar.bar_high)
				cur_bar.bar_high = tk.tick_price;
			if (tk.tick_price < cur_bar.bar_low)
				cur_bar.bar_low = tk.tick_price;
			vsum = {1'b0, cur_bar.bar_volume} + {18'd0, tk.tick_volume};
			cur_bar.bar_volume = vsum[48] ? '1 : vsum[47:0];
		end
		bars_due.push_back(cur_bar);
	endtask

	task automatic check_field(input string name, input logic [47:0] exp_v,
		input logic [47:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period     = PERIOD_RESET;
			cur_bucket = '0;
			bar_live   = 1'b0;
			cur_bar    = '0;
			bars_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				period = cfg_data;
			if (bar_valid && !bar_stall) begin
				if (bars_due.size() == 0) begin
					$display("%0t: bar transaction with no tick behind it: %h", $time, bar);
					mismatches++;
				end else begin
					want = bars_due.pop_front();
					check_field("bar_start", 48'(want.bar_start), 48'(bar.bar_start));
					check_field("bar_open", 48'(want.bar_open), 48'(bar.bar_open));
					check_field("bar_high", 48'(want.bar_high), 48'(bar.bar_high));
					check_field("bar_low", 48'(want.bar_low), 48'(bar.bar_low));
					check_field("bar_close", 48'(want.bar_close), 48'(bar.bar_close));
					check_field("bar_volume", want.bar_volume, bar.bar_volume);
					check_field("new_bar", 48'(want.new_bar), 48'(bar.new_bar));
					check_field("empty_skipped", 48'(want.empty_skipped),
						48'(bar.empty_skipped));
				end
			end
			if (tick_valid && !tick_stall)
				fold_tick(tick);
		end
		outstanding = bars_due.size();
	end

endmodule

@@ tb/sv/ohlcv_bar_time_bucket_core_tb.sv @@
// Top of the bar builder testbench: clock, reset, stimulus, stall control and verdict.
`timescale 1ns / 1ps
module ohlcv_bar_time_bucket_core_tb;
	import obtb_pkg::*;

	// The limit covers the slowest legal run (serial divider per tick, long
	// sender gaps, receiver stalls, one long hold) with a wide margin.
	localparam int CYCLE_LIMIT   = 1000000;
	// Settle time for a tick to pass divider, queue and result register.
	localparam int SETTLE_CYCLES = 40;
	// Long enough to fill divider, queue and result register several times.
	localparam int HOLD_CYCLES   = 500;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data   = '0;
	logic        tick_valid = 1'b0;
	logic        tick_stall;
	tick_t       tick       = '0;
	logic        bar_valid;
	logic        bar_stall  = 1'b0;
	bar_t        bar;

	int mismatches;
	int outstanding;
	int cycles;

	// Idle rates in percent, set per phase by the stimulus process.
	int snd_idle_pct = 7;
	int rcv_idle_pct = 86;

	// Long receiver hold: stimulus bumps hold_reqs, the receiver serves it.
	int hold_reqs  = 0;
	int holds_done = 0;
	int hold_left  = 0;

	// Stimulus planning only: where the tick times stand and the highest
	// bucket sent so far, so each new period starts in a fresh bucket.
	logic [31:0]     last_time   = '0;
	logic [31:0]     eff_period  = PERIOD_RESET;
	longint unsigned top_bucket  = 0;

	ohlcv_bar_time_bucket_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.bar_valid  (bar_valid),
		.bar_stall  (bar_stall),
		.bar        (bar)
	);

	ohlcv_bar_time_bucket_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.tick        (tick),
		.bar_valid   (bar_valid),
		.bar_stall   (bar_stall),
		.bar         (bar),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stall per cycle, or a long hold when one is requested.
	// During the hold the block's queue fills and tick_stall must rise.
	always @(posedge clk) begin
		if (hold_left == 0 && holds_done != hold_reqs) begin
			hold_left = HOLD_CYCLES;
			holds_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			bar_stall <= 1'b1;
		end else begin
			bar_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	function automatic logic [31:0] pick_price();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return $urandom();
	endfunction

	function automatic logic [30:0] pick_volume();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return 31'($urandom());
	endfunction

	// One tick transaction. Valid may drop for random idle cycles first; once
	// raised it holds with a fixed payload until the block takes it.
	task automatic send_tick(input logic [31:0] t, input logic [31:0] price,
		input logic [30:0] vol);
		logic [31:0] bucket;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		tick <= tick_t'{tick_time: t, tick_price: price, tick_volume: vol};
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		last_time = t;
		bucket = t / eff_period;
		if (64'(bucket) > top_bucket)
			top_bucket = 64'(bucket);
	endtask

	// Random tick, mostly well ordered: same bucket, next few buckets, a
	// step back into an older bucket, a long jump (empty buckets, saturation)
	// or a scattered time under the phase's mask.
	task automatic send_random_tick(input logic [31:0] jump_mask);
		logic [63:0] nt;
		logic [31:0] step_cap;
		logic [31:0] back;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		step_cap = (eff_period > 32'd1000) ? 32'd1000 : eff_period;
		if (kind < 50) begin
			nt = 64'(last_time) + 64'($urandom_range(0, step_cap));
		end else if (kind < 75) begin
			nt = 64'(last_time) + 64'(eff_period) * 64'($urandom_range(1, 3));
		end else if (kind < 85) begin
			back = $urandom_range(0, 2 * step_cap);
			nt = (last_time > back) ? 64'(last_time - back) : 64'd0;
		end else if (kind < 95) begin
			nt = 64'(last_time) + 64'($urandom() & jump_mask);
		end else begin
			nt = 64'($urandom() & jump_mask);
		end
		if (nt > 64'hFFFF_FFFF)
			nt = 64'hFFFF_FFFF;
		send_tick(nt[31:0], pick_price(), pick_volume());
	endtask

	// Let every outstanding bar drain, then give the block its latency.
	// The first edge makes sure the checker has seen the last tick.
	task automatic drain();
		@(posedge clk);
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Period register write, only with the block idle.
	task automatic set_period(input logic [31:0] p);
		tick_valid <= 1'b0;
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= p;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		eff_period = (p == '0) ? 32'd1 : p;
	endtask

	// One phase: optional period write, idle rates, optional long hold, then
	// random ticks. After a write the times restart just past the highest
	// bucket reached, so the new period opens bars right away (the maximum
	// period cannot get past bucket 1, so that phase only merges).
	task automatic run_phase(input logic [31:0] p, input bit do_write, input bit hold,
		input int n, input int snd_pct, input int rcv_pct, input logic [31:0] jump_mask);
		logic [63:0] base;
		if (do_write) begin
			set_period(p);
			if (eff_period != 32'hFFFF_FFFF) begin
				base = (64'(top_bucket) + 64'd1 + 64'($urandom_range(0, 3)))
					* 64'(eff_period);
				last_time = (base > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : base[31:0];
			end
		end
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		if (hold)
			hold_reqs++;
		repeat (n) send_random_tick(jump_mask);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset period of 60.
		send_tick(32'd0, 32'd1000, 31'd0);                 // first tick opens a bar
		send_tick(32'd59, 32'hFFFF_FFFF, 31'h7FFF_FFFF);   // merge, high at max
		send_tick(32'd59, 32'd0, 31'h7FFF_FFFF);           // merge, low at zero
		send_tick(32'd60, 32'd5, 31'd1);                   // next bucket, none skipped
		send_tick(32'd30, 32'd7, 31'd2);                   // older bucket merges
		send_tick(32'd119, 32'd3, 31'd3);                  // last time of the bucket
		send_tick(32'd300, 32'd9, 31'd4);                  // three empty buckets
		send_tick(32'd300, 32'd9, 31'd0);                  // same time, same price
		send_tick(32'd360, 32'h8000_0000, 31'h4000_0000);
		send_tick(32'd419, 32'h7FFF_FFFF, 31'h3FFF_FFFF);
		send_tick(32'd420 + 32'd60 * 32'd65535, 32'h5555_5555, 31'h2AAA_AAAA); // skip count at its top
		send_tick(32'd3932520 + 32'd60 * 32'd65537, 32'hAAAA_AAAA, 31'h5555_5555); // skip saturates

		// Sender rarely idles, receiver mostly stalls.
		run_phase(PERIOD_RESET, 1'b0, 1'b0, 110, 7, 86, 32'h000F_FFFF);
		run_phase(32'hFFFF_FFFF, 1'b1, 1'b0, 100, 7, 86, 32'hFFFF_FFFF);
		// Roles swapped.
		run_phase(32'($urandom_range(1000, 5000)), 1'b1, 1'b0, 130, 86, 7, 32'h00FF_FFFF);
		run_phase(PERIOD_RESET, 1'b1, 1'b0, 130, 86, 7, 32'h000F_FFFF);
		// No idling; one long receiver hold to back the block up.
		run_phase(PERIOD_MIN, 1'b1, 1'b1, 140, 0, 0, 32'h000F_FFFF);
		run_phase(32'd0, 1'b1, 1'b0, 140, 0, 0, 32'h000F_FFFF);   // zero acts as one

		tick_valid <= 1'b0;
		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ ohlcv_bar_time_bucket_core.f @@
+incdir+hw/rtl
hw/rtl/obtb_pkg.sv
hw/rtl/obtb_div.sv
hw/rtl/obtb_fifo.sv
hw/rtl/obtb_bar.sv
hw/rtl/ohlcv_bar_time_bucket_core.sv
tb/sv/ohlcv_bar_time_bucket_checker.sv
tb/sv/ohlcv_bar_time_bucket_core_tb.sv
